[src/jpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpm_pkg
// Codes and types shared by the JSON path pushdown matcher.
// ----------------------------------------------------------------------------
package jpm_pkg;

	localparam logic [2:0] TOK_OPEN_BRACE    = 3'd0;
	localparam logic [2:0] TOK_CLOSE_BRACE   = 3'd1;
	localparam logic [2:0] TOK_OPEN_BRACKET  = 3'd2;
	localparam logic [2:0] TOK_CLOSE_BRACKET = 3'd3;
	localparam logic [2:0] TOK_COMMA         = 3'd4;
	localparam logic [2:0] TOK_KEY           = 3'd5;
	localparam logic [2:0] TOK_PRIMITIVE     = 3'd6;

	localparam logic KIND_TABLE = 1'b0;
	localparam logic KIND_TOKEN = 1'b1;

	localparam logic [1:0] SEL_ACCEPT = 2'd0;
	localparam logic [1:0] SEL_RANGE  = 2'd1;
	localparam logic [1:0] SEL_TRANS  = 2'd2;

	localparam logic [1:0] SYN_BRACE   = 2'd1;
	localparam logic [1:0] SYN_BRACKET = 2'd2;
	localparam logic [1:0] SYN_KEY     = 2'd3;

	localparam logic [1:0] ACC_NONE      = 2'd0;
	localparam logic [1:0] ACC_CANDIDATE = 2'd1;
	localparam logic [1:0] ACC_CONDITION = 2'd2;
	localparam logic [1:0] ACC_PREDICATE = 2'd3;

	localparam logic [2:0] TUP_SPAN     = 3'd0;
	localparam logic [2:0] TUP_OPEN     = 3'd1;
	localparam logic [2:0] TUP_CLOSE    = 3'd2;
	localparam logic [2:0] TUP_COND     = 3'd3;
	localparam logic [2:0] TUP_OVERFLOW = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_READ,
		PH_TOP,
		PH_EXEC
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  state;
		logic [31:0] span_start;
		logic [31:0] span_end;
		logic        last;
	} tuple_t;

endpackage

[src/json_path_pushdown_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_path_pushdown_matcher
// Streaming JSON path query engine run as a pushdown automaton on lexed tokens.
// ----------------------------------------------------------------------------
// Usage: token requests (kind 1) and table-write requests (kind 0) enter on
// the token channel (token_valid / token_stall). Match tuples leave on the
// tuple channel (tuple_valid / tuple_stall); each token yields zero, one or
// two tuples, and the final tuple of a token carries last = 1.
// Every request reads its stack tops, the transition entry and the accept and
// range entries of the current state from synchronous memories in its read
// phase, then computes and writes back in its execute phase. A closing bracket
// has an extra phase in between, since it needs a second read of the accept
// and range tables at the state of the saved parent context. The next request
// is taken in the same cycle as the write-back. A tuple enters the queue at
// the write-back edge of its token and, if the queue was empty, is on the
// outputs in the cycle right after that edge.
// Results go to a four-entry queue. The engine completes a request only when
// two slots are free, so a stalled receiver holds back the token channel once
// three or more results are waiting; the request then waits in its compute
// cycle with its table and stack reads held.
// Reset empties both stacks and the queue and loads the current context with
// state 1. The tables and stacks come up undefined until written.
// A write on cfg_we also reloads the current context, with the cfg_wdata state.
module json_path_pushdown_matcher #(
	parameter int STATE_COUNT  = 64,
	parameter int SYMBOL_COUNT = 64,
	parameter int STACK_DEPTH  = 32,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        token_valid,
	output logic        token_stall,
	input  logic        kind,
	input  logic [2:0]  token_code,
	input  logic [5:0]  key_symbol,
	input  logic [31:0] token_start,
	input  logic [31:0] token_end,
	input  logic [1:0]  table_select,
	input  logic [5:0]  table_state,
	input  logic [5:0]  table_symbol,
	input  logic [31:0] table_value,
	output logic        tuple_valid,
	input  logic        tuple_stall,
	output logic [2:0]  tuple_kind,
	output logic [5:0]  match_state,
	output logic [31:0] span_start,
	output logic [31:0] span_end,
	output logic        last
);
	import jpm_pkg::*;

	localparam int STATE_W = $clog2(STATE_COUNT);
	localparam int TR_DEPTH = STATE_COUNT * SYMBOL_COUNT;
	localparam int TR_W = $clog2(TR_DEPTH);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int PTR_W = $clog2(STACK_DEPTH + 1);
	localparam int CTX_W = STATE_W + COUNT_WIDTH + 33;
	localparam int Q_DEPTH = 4;

	// Memories.
	logic [1:0]        acc_mem [STATE_COUNT];
	logic [31:0]       rng_mem [STATE_COUNT];
	logic [STATE_W-1:0] tr_mem [TR_DEPTH];
	logic [1:0]        syn_mem [STACK_DEPTH];
	logic [CTX_W-1:0]  ctx_mem [STACK_DEPTH];

	logic [1:0]         acc_q;
	logic [31:0]        rng_q;
	logic [STATE_W-1:0] tr_q;
	logic [1:0]         syn0_q, syn1_q;
	logic [CTX_W-1:0]   ctx0_q, ctx1_q;

	// Control and context registers.
	phase_t phase_q, phase_nxt;
	logic [PTR_W-1:0]       sp_q, cp_q, sp_nxt, cp_nxt;
	logic [STATE_W-1:0]     cur_state_q, cur_state_nxt;
	logic [COUNT_WIDTH-1:0] cur_count_q, cur_count_nxt;
	logic [31:0]            cur_start_q, cur_start_nxt;
	logic                   cur_valid_q, cur_valid_nxt;

	// Request register.
	logic        kind_q;
	logic [2:0]  ttype_q;
	logic [5:0]  ksym_q;
	logic [31:0] tstart_q, tend_q;
	logic [1:0]  tsel_q;
	logic [5:0]  tstate_q, tsym_q;
	logic [31:0] tvalue_q;

	// Result queue.
	tuple_t                  q_mem [Q_DEPTH];
	logic [1:0]              q_rd_q, q_wr_q;
	logic [2:0]              q_cnt_q;

	logic accept, go, pop;

	// Write ports driven by the execute logic.
	logic               acc_we, rng_we, tr_we, syn_we, ctx_we;
	logic [STATE_W-1:0] tab_waddr;
	logic [TR_W-1:0]    tr_waddr;
	logic [STATE_W-1:0] tr_wdata;
	logic [1:0]         syn_wdata;
	logic [CTX_W-1:0]   ctx_wdata;

	// Read addresses.
	logic [STATE_W-1:0] tab_raddr;
	logic [TR_W-1:0]    tr_raddr;
	logic [ADDR_W-1:0]  syn_ra0, syn_ra1;

	// Emitted tuples.
	tuple_t     em0, em1;
	logic [1:0] em_n;

	// Unpacked stack tops.
	logic [STATE_W-1:0]     top_state, sec_state;
	logic [COUNT_WIDTH-1:0] top_count, sec_count;
	logic [31:0]            top_start, sec_start;
	logic                   top_valid, sec_valid;

	function automatic logic range_ok(input logic [31:0] rng, input logic [COUNT_WIDTH-1:0] cnt);
		logic [31:0] lo, hi, c;
		lo = {16'd0, rng[15:0]};
		hi = {16'd0, rng[31:16]};
		c = 32'(cnt);
		return (lo == 32'd0 && hi == 32'd0) || (c >= lo && c < hi);
	endfunction

	function automatic logic [STATE_W-1:0] clamp_state(input logic [31:0] v);
		return (v < 32'(STATE_COUNT)) ? STATE_W'(v) : '0;
	endfunction

	assign accept = token_valid && !token_stall;
	assign go = (phase_q == PH_EXEC) && (q_cnt_q <= 3'(Q_DEPTH - 2));
	assign token_stall = !((phase_q == PH_IDLE) || go);
	assign pop = tuple_valid && !tuple_stall;

	// Stack tops: an empty context stack reads as the dead context.
	always_comb begin
		if (cp_q == '0) begin
			top_state = '0;
			top_count = '0;
			top_start = '0;
			top_valid = 1'b0;
		end else begin
			{top_state, top_count, top_start, top_valid} = ctx0_q;
		end
		if (cp_q < PTR_W'(2)) begin
			sec_state = '0;
			sec_count = '0;
			sec_start = '0;
			sec_valid = 1'b0;
		end else begin
			{sec_state, sec_count, sec_start, sec_valid} = ctx1_q;
		end
	end

	// The accept and range tables are read at the current state first. A
	// closing bracket reads them at the parent state from its extra cycle on
	// and keeps that address while it waits for queue space.
	assign tab_raddr = (kind_q == KIND_TOKEN && ttype_q == TOK_CLOSE_BRACKET
		&& (phase_q == PH_TOP || phase_q == PH_EXEC)) ? top_state : cur_state_q;
	assign tr_raddr = TR_W'(32'(cur_state_q) * SYMBOL_COUNT
		+ ((ttype_q == TOK_KEY) ? 32'(ksym_q) : 32'(SYMBOL_COUNT - 1)));
	assign syn_ra0 = ADDR_W'(sp_q - PTR_W'(1));
	assign syn_ra1 = ADDR_W'(sp_q - PTR_W'(2));

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[tab_waddr] <= tvalue_q[1:0];
		end
		if (rng_we) begin
			rng_mem[tab_waddr] <= tvalue_q;
		end
		if (tr_we) begin
			tr_mem[tr_waddr] <= tr_wdata;
		end
		if (syn_we) begin
			syn_mem[ADDR_W'(sp_q)] <= syn_wdata;
		end
		if (ctx_we) begin
			ctx_mem[ADDR_W'(cp_q)] <= ctx_wdata;
		end
		acc_q <= acc_mem[tab_raddr];
		rng_q <= rng_mem[tab_raddr];
		tr_q <= tr_mem[tr_raddr];
		syn0_q <= syn_mem[syn_ra0];
		syn1_q <= syn_mem[syn_ra1];
		ctx0_q <= ctx_mem[ADDR_W'(cp_q - PTR_W'(1))];
		ctx1_q <= ctx_mem[ADDR_W'(cp_q - PTR_W'(2))];
	end

	// Sequencer next state.
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (accept) phase_nxt = PH_READ;
			end
			PH_READ: begin
				if (kind_q == KIND_TOKEN && ttype_q == TOK_CLOSE_BRACKET)
					phase_nxt = PH_TOP;
				else
					phase_nxt = PH_EXEC;
			end
			PH_TOP: phase_nxt = PH_EXEC;
			PH_EXEC: begin
				if (accept) phase_nxt = PH_READ;
				else if (go) phase_nxt = PH_IDLE;
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

	// Execute: stack and context update, table writes and tuple emission.
	always_comb begin
		logic [1:0] m;
		logic       full;
		logic       st_ok;
		cur_state_nxt = cur_state_q;
		cur_count_nxt = cur_count_q;
		cur_start_nxt = cur_start_q;
		cur_valid_nxt = cur_valid_q;
		sp_nxt = sp_q;
		cp_nxt = cp_q;
		acc_we = 1'b0;
		rng_we = 1'b0;
		tr_we = 1'b0;
		syn_we = 1'b0;
		ctx_we = 1'b0;
		syn_wdata = SYN_BRACE;
		ctx_wdata = '0;
		tab_waddr = STATE_W'(tstate_q);
		tr_waddr = TR_W'(32'(tstate_q) * SYMBOL_COUNT + 32'(tsym_q));
		tr_wdata = clamp_state(tvalue_q);
		em0 = '0;
		em1 = '0;
		em_n = 2'd0;
		full = (32'(sp_q) >= 32'(STACK_DEPTH)) || (32'(cp_q) >= 32'(STACK_DEPTH));
		st_ok = 32'(tstate_q) < 32'(STATE_COUNT);
		m = acc_q;
		if (m == ACC_CANDIDATE && !range_ok(rng_q, cur_count_q)) m = ACC_NONE;

		if (go) begin
			if (kind_q == KIND_TABLE) begin
				if (st_ok) begin
					case (tsel_q)
						SEL_ACCEPT: acc_we = 1'b1;
						SEL_RANGE: rng_we = 1'b1;
						SEL_TRANS: tr_we = 32'(tsym_q) < 32'(SYMBOL_COUNT);
						default: ;
					endcase
				end
			end else begin
				case (ttype_q)
					TOK_OPEN_BRACE: begin
						if (32'(sp_q) >= 32'(STACK_DEPTH)) begin
							em0 = '{TUP_OVERFLOW, 6'(cur_state_q), 32'd0, 32'd0, 1'b0};
							em_n = 2'd1;
						end else begin
							syn_we = 1'b1;
							syn_wdata = SYN_BRACE;
							sp_nxt = sp_q + PTR_W'(1);
						end
						if (m == ACC_CANDIDATE) begin
							cur_start_nxt = tstart_q;
							cur_valid_nxt = 1'b1;
						end else if (m == ACC_PREDICATE || m == ACC_CONDITION) begin
							if (em_n == 2'd0)
								em0 = '{(m == ACC_PREDICATE) ? TUP_OPEN : TUP_COND,
									6'(cur_state_q), 32'd0, 32'd0, 1'b0};
							else
								em1 = '{(m == ACC_PREDICATE) ? TUP_OPEN : TUP_COND,
									6'(cur_state_q), 32'd0, 32'd0, 1'b0};
							em_n = em_n + 2'd1;
						end
					end
					TOK_CLOSE_BRACE: begin
						if (cur_valid_q && m == ACC_CANDIDATE) begin
							em0 = '{TUP_SPAN, 6'(cur_state_q), cur_start_q, tend_q, 1'b0};
							em_n = 2'd1;
						end
						if (sp_q == PTR_W'(1)) begin
							sp_nxt = '0;
						end else if (sp_q > PTR_W'(1)) begin
							if (syn1_q == SYN_KEY) begin
								cur_state_nxt = top_state;
								cur_count_nxt = top_count;
								cur_start_nxt = top_start;
								cur_valid_nxt = top_valid;
								if (cp_q != '0) cp_nxt = cp_q - PTR_W'(1);
								sp_nxt = sp_q - PTR_W'(2);
							end else if (syn1_q == SYN_BRACKET) begin
								sp_nxt = sp_q - PTR_W'(1);
								if (cur_count_q != '1) cur_count_nxt = cur_count_q + 1'b1;
								// A predicate state does not depend on the count.
								if (acc_q == ACC_PREDICATE) begin
									if (em_n == 2'd0)
										em0 = '{TUP_CLOSE, 6'(cur_state_q), 32'd0, 32'd0, 1'b0};
									else
										em1 = '{TUP_CLOSE, 6'(cur_state_q), 32'd0, 32'd0, 1'b0};
									em_n = em_n + 2'd1;
								end
							end
						end
					end
					TOK_OPEN_BRACKET, TOK_KEY: begin
						if (ttype_q == TOK_OPEN_BRACKET) begin
							if (m == ACC_CANDIDATE) begin
								cur_start_nxt = tstart_q;
								cur_valid_nxt = 1'b1;
							end else if (m == ACC_CONDITION) begin
								em0 = '{TUP_COND, 6'(cur_state_q), 32'd0, 32'd0, 1'b0};
								em_n = 2'd1;
							end
						end
						if (full) begin
							if (em_n == 2'd0)
								em0 = '{TUP_OVERFLOW, 6'(cur_state_q), 32'd0, 32'd0, 1'b0};
							else
								em1 = '{TUP_OVERFLOW, 6'(cur_state_q), 32'd0, 32'd0, 1'b0};
							em_n = em_n + 2'd1;
						end else begin
							syn_we = 1'b1;
							syn_wdata = (ttype_q == TOK_KEY) ? SYN_KEY : SYN_BRACKET;
							sp_nxt = sp_q + PTR_W'(1);
							ctx_we = 1'b1;
							ctx_wdata = {cur_state_q, cur_count_q, cur_start_nxt, cur_valid_nxt};
							cp_nxt = cp_q + PTR_W'(1);
							cur_state_nxt = '0;
							if (range_ok(rng_q, cur_count_q)
								&& (ttype_q != TOK_KEY || 32'(ksym_q) < 32'(SYMBOL_COUNT)))
								cur_state_nxt = tr_q;
							cur_count_nxt = '0;
							cur_start_nxt = '0;
							cur_valid_nxt = 1'b0;
						end
					end
					TOK_CLOSE_BRACKET: begin
						if (sp_q != '0) begin
							// Here the table registers hold the parent's entries.
							if (top_valid && acc_q == ACC_CANDIDATE && range_ok(rng_q, top_count)) begin
								em0 = '{TUP_SPAN, 6'(top_state), top_start, tend_q, 1'b0};
								em_n = 2'd1;
							end
							if (sp_q == PTR_W'(1)) begin
								cur_state_nxt = top_state;
								cur_count_nxt = top_count;
								cur_start_nxt = top_start;
								cur_valid_nxt = 1'b0;
								if (cp_q != '0) cp_nxt = cp_q - PTR_W'(1);
								sp_nxt = '0;
							end else if (syn1_q == SYN_KEY) begin
								cur_state_nxt = sec_state;
								cur_count_nxt = sec_count;
								cur_start_nxt = sec_start;
								cur_valid_nxt = sec_valid;
								cp_nxt = (cp_q >= PTR_W'(2)) ? cp_q - PTR_W'(2) : '0;
								sp_nxt = sp_q - PTR_W'(2);
							end else if (syn1_q == SYN_BRACKET) begin
								cur_state_nxt = top_state;
								cur_count_nxt = (top_count != '1) ? top_count + 1'b1 : top_count;
								cur_start_nxt = top_start;
								cur_valid_nxt = 1'b0;
								if (cp_q != '0) cp_nxt = cp_q - PTR_W'(1);
								sp_nxt = sp_q - PTR_W'(1);
							end
						end
					end
					TOK_PRIMITIVE: begin
						if (sp_q != '0) begin
							if (m == ACC_CANDIDATE || m == ACC_CONDITION) begin
								em0 = '{TUP_SPAN, 6'(cur_state_q), tstart_q, tend_q, 1'b0};
								em_n = 2'd1;
							end
							if (syn0_q == SYN_KEY) begin
								cur_state_nxt = top_state;
								cur_count_nxt = top_count;
								cur_start_nxt = top_start;
								cur_valid_nxt = top_valid;
								if (cp_q != '0) cp_nxt = cp_q - PTR_W'(1);
								sp_nxt = sp_q - PTR_W'(1);
							end else if (syn0_q == SYN_BRACKET) begin
								if (cur_count_q != '1) cur_count_nxt = cur_count_q + 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end
		if (em_n == 2'd1) em0.last = 1'b1;
		if (em_n == 2'd2) em1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sp_q <= '0;
			cp_q <= '0;
			cur_state_q <= clamp_state(32'd1);
			cur_count_q <= '0;
			cur_start_q <= '0;
			cur_valid_q <= 1'b0;
			q_rd_q <= '0;
			q_wr_q <= '0;
			q_cnt_q <= '0;
		end else begin
			phase_q <= phase_nxt;
			sp_q <= sp_nxt;
			cp_q <= cp_nxt;
			if (cfg_we) begin
				cur_state_q <= clamp_state(32'(cfg_wdata));
				cur_count_q <= '0;
				cur_start_q <= '0;
				cur_valid_q <= 1'b0;
			end else begin
				cur_state_q <= cur_state_nxt;
				cur_count_q <= cur_count_nxt;
				cur_start_q <= cur_start_nxt;
				cur_valid_q <= cur_valid_nxt;
			end
			q_wr_q <= q_wr_q + em_n;
			if (pop) q_rd_q <= q_rd_q + 2'd1;
			q_cnt_q <= q_cnt_q + 3'(em_n) - 3'(pop);
		end
	end

	// Request and queue payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			ttype_q <= token_code;
			ksym_q <= key_symbol;
			tstart_q <= token_start;
			tend_q <= token_end;
			tsel_q <= table_select;
			tstate_q <= table_state;
			tsym_q <= table_symbol;
			tvalue_q <= table_value;
		end
		if (em_n != 2'd0) q_mem[q_wr_q] <= em0;
		if (em_n == 2'd2) q_mem[q_wr_q + 2'd1] <= em1;
	end

	assign tuple_valid = q_cnt_q != '0;
	assign tuple_kind = q_mem[q_rd_q].kind;
	assign match_state = q_mem[q_rd_q].state;
	assign span_start = q_mem[q_rd_q].span_start;
	assign span_end = q_mem[q_rd_q].span_end;
	assign last = q_mem[q_rd_q].last;

endmodule
